// ===== hw/rtl/slda_pkg.sv =====
// Shared kinds, fixed constants and elaboration-time table functions of the log-domain adder.
package slda_pkg;

   localparam int CODE_W = 32;
   localparam int KIND_W = 2;
   // Corrections are tabulated for differences below 2^SPAN_BITS.
   localparam int SPAN_BITS = 4;
   localparam int SERIES_TERMS = 24;
   localparam logic [63:0] Q_ONE = 64'h0000_0001_0000_0000;
   localparam logic [63:0] LN2_Q32 = 64'd2977044472;

   typedef logic [KIND_W-1:0] kind_type;

   localparam kind_type KIND_ORDINARY = 2'd0;
   localparam kind_type KIND_LOG_ZERO = 2'd2;

   // A result that skips the arithmetic path: operand pass-through or exact cancellation.
   typedef struct packed {
      logic take;
      logic [CODE_W-1:0] code;
      kind_type kind;
   } bypass_type;

   // Restoring long division, used only while the correction tables are built.
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], num[i]};
         if (rem >= {1'b0, den}) begin
            rem = rem - {1'b0, den};
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // e^-x with x and the result in Q32.
   function automatic logic [63:0] exp_neg_q32(input logic [63:0] x);
      logic [63:0] k;
      logic [63:0] r;
      logic [63:0] term;
      logic [63:0] pos;
      logic [63:0] neg;
      logic [63:0] e;
      k = udiv64(x, LN2_Q32);
      r = x - k * LN2_Q32;
      term = Q_ONE;
      pos = Q_ONE;
      neg = '0;
      for (int n = 1; n <= SERIES_TERMS; n++) begin
         term = udiv64((term * r) >> 32, 64'(n));
         if (n[0]) begin
            neg = neg + term;
         end else begin
            pos = pos + term;
         end
      end
      e = (pos > neg) ? pos - neg : 64'd0;
      if (k >= 64'd64) begin
         return 64'd0;
      end
      return e >> k;
   endfunction

   // Natural log of a positive Q32 value, result in signed Q32.
   function automatic longint ln_q32(input logic [63:0] z_arg);
      logic [63:0] z;
      logic [63:0] t;
      logic [63:0] t2;
      logic [63:0] pw;
      logic [63:0] sum;
      int k;
      z = z_arg;
      k = 0;
      sum = '0;
      if (z == 64'd0) begin
         z = 64'd1;
      end
      while (z < Q_ONE) begin
         z = z << 1;
         k++;
      end
      while (z >= (Q_ONE << 1)) begin
         z = z >> 1;
         k--;
      end
      t = udiv64((z - Q_ONE) << 32, z + Q_ONE);
      t2 = (t * t) >> 32;
      pw = t;
      for (int n = 0; n < SERIES_TERMS; n++) begin
         sum = sum + udiv64(pw, 64'(2 * n + 1));
         pw = (pw * t2) >> 32;
      end
      return longint'(sum << 1) - longint'(k) * longint'(LN2_Q32);
   endfunction

   // Correction at the middle of bin idx, rounded half away from zero to frac fraction bits.
   function automatic longint corr_entry(input logic [63:0] idx, input logic same,
                                         input int frac, input int tib);
      logic [63:0] dq;
      logic [63:0] y;
      logic [63:0] mag;
      longint v;
      logic neg;
      dq = ((idx << 1) + 64'd1) << (32 + SPAN_BITS - 1 - tib);
      y = exp_neg_q32(dq);
      if (y >= Q_ONE) begin
         y = Q_ONE - 64'd1;
      end
      v = same ? ln_q32(Q_ONE + y) : ln_q32(Q_ONE - y);
      neg = (v < 0);
      mag = neg ? 64'd0 - 64'(v) : 64'(v);
      if (frac >= 32) begin
         mag = mag << (frac - 32);
      end else begin
         mag = (mag + (64'd1 << (31 - frac))) >> (32 - frac);
      end
      return neg ? -longint'(mag) : longint'(mag);
   endfunction

endpackage

// ===== hw/rtl/slda_corr_rom.sv =====
// Correction table ROM: ln(1+e^-d) in the upper half, ln(1-e^-d) in the lower half.
module slda_corr_rom import slda_pkg::*; #(
   parameter int FRAC_BITS = 16,
   parameter int TABLE_INDEX_BITS = 10
) (
   input  logic                         clock,
   input  logic                         enable,
   input  logic [TABLE_INDEX_BITS:0]    addr,
   output logic signed [FRAC_BITS+5:0]  entry
);

   // The opposite-sign correction is most negative in the first bin, about -4.9 here and
   // under -8 even with the finest table, so five integer bits plus sign hold every entry.
   localparam int CORR_W = FRAC_BITS + 6;
   localparam int HALF = 2 ** TABLE_INDEX_BITS;
   localparam int DEPTH = 2 * HALF;

   logic signed [CORR_W-1:0] rom_image [DEPTH];
   logic signed [CORR_W-1:0] entry_ff;

   for (genvar i = 0; i < DEPTH; i++) begin : g_entry
      localparam longint VALUE = corr_entry(64'(i % HALF), (i >= HALF), FRAC_BITS,
                                            TABLE_INDEX_BITS);
      assign rom_image[i] = CORR_W'(VALUE);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         entry_ff <= rom_image[addr];
      end
   end

   assign entry = entry_ff;

endmodule

// ===== hw/rtl/signed_log_domain_adder_top.sv =====
// Signed log-domain adder: five-stage pipeline with a registered correction table.
//
// Each request transaction carries two operands, each a log code with a kind
// (ordinary, unset sentinel, log zero). Each response transaction carries the
// log code and kind of their sum. Responses come back in request order, one
// per request.
// A new request can be taken every cycle while the receiver is ready, so the
// sustained rate is one transaction per cycle; the path is decode, compare and
// subtract, table read, correction add, then sign and saturate into the output
// register. Each stage holds its own valid bit. A stage loads whenever it is
// empty or the stage after it moves, so a stalled receiver holds the response
// in place while empty stages behind it keep filling; req_ready drops only
// once every stage is full.
// Reset empties all stages; there is no other state and no clearing pass.
module signed_log_domain_adder_top import slda_pkg::*; #(
   parameter int CODE_BITS = 32,
   parameter int FRAC_BITS = 16,
   parameter int TABLE_INDEX_BITS = 10
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [CODE_W-1:0] req_a_code,
   input  logic [KIND_W-1:0]        req_a_kind,
   input  logic signed [CODE_W-1:0] req_b_code,
   input  logic [KIND_W-1:0]        req_b_kind,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [CODE_W-1:0] rsp_sum_code,
   output logic [KIND_W-1:0]        rsp_sum_kind
);

   localparam int CORR_W = FRAC_BITS + 6;
   localparam int MW = ((CORR_W > CODE_W) ? CORR_W : CODE_W) + 1;
   localparam int CDW = MW + 1;
   localparam int SW = (CDW > CODE_BITS) ? CDW : CODE_BITS;
   localparam int FAR_W = (FRAC_BITS + SPAN_BITS + 1 > CODE_W) ?
                          FRAC_BITS + SPAN_BITS + 1 : CODE_W;
   localparam int IW = CODE_W + TABLE_INDEX_BITS;
   localparam logic [FAR_W-1:0] FAR_LIMIT = FAR_W'(1) << (FRAC_BITS + SPAN_BITS);
   localparam logic signed [SW-1:0] CODE_MAX = {{(SW - CODE_BITS + 1){1'b0}},
                                                {(CODE_BITS - 1){1'b1}}};
   localparam logic signed [SW-1:0] CODE_MIN = ~CODE_MAX;

   // Stage valids and advance enables.
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic en1, en2, en3, en4, en5;

   // Stage 1: operand decode.
   bypass_type               byp1_in, byp1_ff;
   logic signed [CODE_W-1:0] ma1_in, mb1_in, ma1_ff, mb1_ff;
   logic                     pa1_ff, pb1_ff;

   // Stage 2: magnitude compare and difference.
   logic signed [CODE_W:0]   diff2, neg_diff2;
   logic                     ge2;
   logic [CODE_W-1:0]        d2;
   logic [IW-1:0]            d_scaled2;
   bypass_type               byp2_in, byp2_ff;
   logic signed [CODE_W-1:0] big2_in, big2_ff;
   logic                     psum2_ff, same2_ff, far2_ff;
   logic [TABLE_INDEX_BITS-1:0] idx2_ff;

   // Stage 3: table read.
   logic signed [CORR_W-1:0] corr3;
   bypass_type               byp3_ff;
   logic signed [CODE_W-1:0] big3_ff;
   logic                     psum3_ff, far3_ff;

   // Stage 4: correction add.
   logic signed [MW-1:0]     corr_add4, m4_in, m4_ff;
   bypass_type               byp4_ff;
   logic                     psum4_ff;

   // Stage 5: sign, saturation and output register.
   logic signed [CDW-1:0]    code5;
   logic signed [SW-1:0]     code_wide5, code_sat5;
   logic [CODE_W-1:0]        sum_code_in, sum_code_ff;
   kind_type                 sum_kind_in, sum_kind_ff;

   assign en5 = !v5_ff || rsp_ready;
   assign en4 = !v4_ff || en5;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
      end
   end

   always_comb begin
      byp1_in.take = 1'b0;
      byp1_in.code = req_a_code;
      byp1_in.kind = req_a_kind;
      if (req_a_kind != KIND_ORDINARY) begin
         byp1_in.take = 1'b1;
         byp1_in.code = req_b_code;
         byp1_in.kind = req_b_kind;
      end else if (req_b_kind != KIND_ORDINARY || req_a_code == '0 || req_b_code == '0) begin
         byp1_in.take = 1'b1;
      end
   end

   // Log magnitude is the code itself when negative, its negation otherwise.
   assign ma1_in = req_a_code[CODE_W-1] ? req_a_code : -req_a_code;
   assign mb1_in = req_b_code[CODE_W-1] ? req_b_code : -req_b_code;

   always_ff @(posedge clock) begin
      if (en1) begin
         byp1_ff <= byp1_in;
         ma1_ff <= ma1_in;
         mb1_ff <= mb1_in;
         pa1_ff <= req_a_code[CODE_W-1];
         pb1_ff <= req_b_code[CODE_W-1];
      end
   end

   assign diff2 = {ma1_ff[CODE_W-1], ma1_ff} - {mb1_ff[CODE_W-1], mb1_ff};
   assign neg_diff2 = -diff2;
   assign ge2 = !diff2[CODE_W];
   assign d2 = ge2 ? diff2[CODE_W-1:0] : neg_diff2[CODE_W-1:0];
   assign big2_in = ge2 ? ma1_ff : mb1_ff;
   assign d_scaled2 = {d2, {TABLE_INDEX_BITS{1'b0}}} >> (FRAC_BITS + SPAN_BITS);

   always_comb begin
      byp2_in = byp1_ff;
      // Opposite signs with equal magnitudes cancel to log zero.
      if (!byp1_ff.take && pa1_ff != pb1_ff && d2 == '0) begin
         byp2_in.take = 1'b1;
         byp2_in.code = '0;
         byp2_in.kind = KIND_LOG_ZERO;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         byp2_ff <= byp2_in;
         big2_ff <= big2_in;
         psum2_ff <= ge2 ? pa1_ff : pb1_ff;
         same2_ff <= (pa1_ff == pb1_ff);
         far2_ff <= (FAR_W'(d2) >= FAR_LIMIT);
         idx2_ff <= d_scaled2[TABLE_INDEX_BITS-1:0];
      end
   end

   slda_corr_rom #(
      .FRAC_BITS(FRAC_BITS),
      .TABLE_INDEX_BITS(TABLE_INDEX_BITS)
   ) u_corr_rom (
      .clock(clock),
      .enable(en3),
      .addr({same2_ff, idx2_ff}),
      .entry(corr3)
   );

   always_ff @(posedge clock) begin
      if (en3) begin
         byp3_ff <= byp2_ff;
         big3_ff <= big2_ff;
         psum3_ff <= psum2_ff;
         far3_ff <= far2_ff;
      end
   end

   assign corr_add4 = far3_ff ? '0 : MW'(corr3);
   assign m4_in = MW'(big3_ff) + corr_add4;

   always_ff @(posedge clock) begin
      if (en4) begin
         byp4_ff <= byp3_ff;
         psum4_ff <= psum3_ff;
         m4_ff <= m4_in;
      end
   end

   assign code5 = psum4_ff ? CDW'(m4_ff) : -CDW'(m4_ff);
   assign code_wide5 = SW'(code5);

   always_comb begin
      if (code_wide5 > CODE_MAX) begin
         code_sat5 = CODE_MAX;
      end else if (code_wide5 < CODE_MIN) begin
         code_sat5 = CODE_MIN;
      end else begin
         code_sat5 = code_wide5;
      end
      sum_code_in = byp4_ff.take ? byp4_ff.code : code_sat5[CODE_W-1:0];
      sum_kind_in = byp4_ff.take ? byp4_ff.kind : KIND_ORDINARY;
   end

   always_ff @(posedge clock) begin
      if (en5) begin
         sum_code_ff <= sum_code_in;
         sum_kind_ff <= sum_kind_in;
      end
   end

   assign rsp_valid = v5_ff;
   assign rsp_sum_code = sum_code_ff;
   assign rsp_sum_kind = sum_kind_ff;

endmodule

// ===== hw/rtl/slda_checker.sv =====
// Port-level checker for the log-domain adder and its bind to the top level.
module slda_checker import slda_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic signed [CODE_W-1:0] req_a_code,
   input logic [KIND_W-1:0]        req_a_kind,
   input logic signed [CODE_W-1:0] req_b_code,
   input logic [KIND_W-1:0]        req_b_kind,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic signed [CODE_W-1:0] rsp_sum_code,
   input logic [KIND_W-1:0]        rsp_sum_kind
);

   // Reset leaves no response pending.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A stalled response holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sum_code) && $stable(rsp_sum_kind))
      else $error("stalled response changed");

   // With the output stage empty, the whole pipeline can advance.
   assert property (@(posedge clock) disable iff (reset) !rsp_valid |-> req_ready)
      else $error("request not ready while output stage empty");

   // An accepted transaction reaches the output when the receiver keeps up.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && rsp_ready) ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready
      ##1 rsp_ready |=> rsp_valid)
      else $error("response missing after five cycles");

endmodule

bind signed_log_domain_adder_top slda_checker u_slda_checker (.*);
